[src/mst_pkg.sv]
// Package with shared types and constants of the minimum spanning tree engine.
`timescale 1ns / 1ps
package mst_pkg;
	localparam int NODE_W  = 4;
	localparam int COST_W  = 16;
	localparam int TOTAL_W = 20;
	localparam logic [COST_W-1:0]  NO_EDGE   = 16'hFFFF;
	localparam logic [TOTAL_W-1:0] TOTAL_MAX = 20'hFFFFF;

	typedef struct packed {
		logic [NODE_W-1:0] row_node;
		logic [NODE_W-1:0] col_node;
		logic [COST_W-1:0] edge_cost;
		logic              final_entry;
	} req_t;

	typedef struct packed {
		logic [NODE_W-1:0]  tree_from;
		logic [NODE_W-1:0]  tree_to;
		logic [COST_W-1:0]  tree_cost;
		logic [TOTAL_W-1:0] running_total;
		logic               disconnected;
		logic               last_edge;
	} res_t;

	typedef struct packed {
		logic load;
		logic row_start;
		logic issue;
		logic decide;
	} ctl_cmd_t;

	typedef struct packed {
		logic final_acc;
		logic col_last;
		logic row_last;
		logic out_fire;
		logic done;
	} ctl_sts_t;
endpackage

[src/mst_chan_if.sv]
// Valid/ready channel interface carrying one payload of a parameter type.
`timescale 1ns / 1ps
interface mst_chan_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

[src/mst_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module mst_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end
endmodule

[src/mst_ctrl.sv]
// Controller state machine that sequences loading, scan rounds and result output.
`timescale 1ns / 1ps
module mst_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  mst_pkg::ctl_sts_t sts,
	output mst_pkg::ctl_cmd_t cmd
);
	import mst_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_ROW    = 6'b000010,
		S_SCAN   = 6'b000100,
		S_DRAIN  = 6'b001000,
		S_DECIDE = 6'b010000,
		S_EMIT   = 6'b100000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				cmd.load = 1'b1;
				if (sts.final_acc) state_d = S_ROW;
			end
			S_ROW: begin
				cmd.row_start = 1'b1;
				state_d = S_SCAN;
			end
			S_SCAN: begin
				cmd.issue = 1'b1;
				if (sts.col_last) state_d = sts.row_last ? S_DRAIN : S_ROW;
			end
			S_DRAIN: state_d = S_DECIDE;
			S_DECIDE: begin
				cmd.decide = 1'b1;
				state_d = S_EMIT;
			end
			S_EMIT: begin
				if (sts.out_fire) state_d = sts.done ? S_IDLE : S_ROW;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

`ifndef SYNTHESIS
	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n) $onehot(state_q))
		else $error("Controller state is not one-hot.");
	a_emit_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT && !sts.out_fire) |=> state_q == S_EMIT)
		else $error("Controller left the output state before the result was taken.");
	a_decide_once: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.decide |=> !cmd.decide)
		else $error("Two decisions in a row.");
`endif
endmodule

[src/mst_dpath.sv]
// Datapath: matrix memory, set labels, minimum search and output register.
`timescale 1ns / 1ps
module mst_dpath #(
	parameter int NODES = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  mst_pkg::ctl_cmd_t cmd,
	output mst_pkg::ctl_sts_t sts,
	mst_chan_if.sink          req,
	mst_chan_if.source        res
);
	import mst_pkg::*;

	localparam int NW    = (NODES > 1) ? $clog2(NODES) : 1;
	localparam int AW    = 2 * NW;
	localparam int DEPTH = 1 << AW;
	localparam logic [NW-1:0] LAST_IDX = NW'(NODES - 1);
	localparam logic [NW-1:0] LAST_EDGE_IDX = NW'(NODES - 2);

	logic [NW-1:0] i_q, j_q, row_lab_q, j_s1, i_s1, lab_s1;
	logic [NW-1:0] lab_q [NODES];
	logic [NW-1:0] bi_q, bj_q, best_li_q, best_lj_q, edges_q;
	logic [COST_W-1:0] best_q, rd_data;
	logic found_q, valid_s1, cross_s1;
	logic [TOTAL_W-1:0] total_q;
	logic [TOTAL_W:0] sum;
	logic in_range, acc, out_fire, round_begin, better;
	res_t out_q;
	logic out_valid_q;

	assign acc = req.valid && req.ready;
	assign req.ready = cmd.load;
	assign in_range = (int'(req.payload.row_node) < NODES) && (int'(req.payload.col_node) < NODES);
	assign out_fire = res.valid && res.ready;
	assign res.valid = out_valid_q;
	assign res.payload = out_q;

	assign sts.final_acc = acc && req.payload.final_entry;
	assign sts.col_last = (j_q == LAST_IDX);
	assign sts.row_last = (i_q == LAST_IDX);
	assign sts.out_fire = out_fire;
	assign sts.done = out_q.last_edge;

	assign round_begin = sts.final_acc || (out_fire && !out_q.last_edge);
	assign better = valid_s1 && cross_s1 && (rd_data < best_q);
	assign sum = {1'b0, total_q} + (TOTAL_W + 1)'(best_q);

	mst_ram #(.WIDTH(COST_W), .DEPTH(DEPTH)) u_cost_ram (
		.clk     (clk),
		.wr_en   (acc && in_range),
		.wr_addr ({NW'(req.payload.row_node), NW'(req.payload.col_node)}),
		.wr_data (req.payload.edge_cost),
		.rd_en   (cmd.issue),
		.rd_addr ({i_q, j_q}),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NODES; k++) lab_q[k] <= NW'(k);
			i_q <= '0;
			j_q <= '0;
			valid_s1 <= 1'b0;
			found_q <= 1'b0;
			best_q <= NO_EDGE;
			total_q <= '0;
			edges_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			valid_s1 <= cmd.issue;
			if (sts.final_acc) begin
				for (int k = 0; k < NODES; k++) lab_q[k] <= NW'(k);
				total_q <= '0;
				edges_q <= '0;
			end
			if (round_begin) begin
				i_q <= '0;
				best_q <= NO_EDGE;
				found_q <= 1'b0;
			end else if (better) begin
				best_q <= rd_data;
				found_q <= 1'b1;
			end
			if (cmd.row_start) j_q <= '0;
			if (cmd.issue) begin
				j_q <= j_q + 1'b1;
				if (sts.col_last && !sts.row_last) i_q <= i_q + 1'b1;
			end
			if (out_fire) out_valid_q <= 1'b0;
			if (cmd.decide) begin
				out_valid_q <= 1'b1;
				if (found_q) begin
					for (int k = 0; k < NODES; k++) begin
						if (lab_q[k] == best_li_q) lab_q[k] <= best_lj_q;
					end
					total_q <= sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];
					edges_q <= edges_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.row_start) row_lab_q <= lab_q[i_q];
		if (cmd.issue) begin
			j_s1 <= j_q;
			i_s1 <= i_q;
			lab_s1 <= lab_q[j_q];
			cross_s1 <= (lab_q[j_q] != row_lab_q);
		end
		if (better) begin
			bi_q <= i_s1;
			bj_q <= j_s1;
			best_li_q <= row_lab_q;
			best_lj_q <= lab_s1;
		end
		if (cmd.decide) begin
			if (found_q) begin
				out_q.tree_from <= NODE_W'(bi_q);
				out_q.tree_to <= NODE_W'(bj_q);
				out_q.tree_cost <= best_q;
				out_q.running_total <= sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];
				out_q.disconnected <= 1'b0;
				out_q.last_edge <= (edges_q == LAST_EDGE_IDX);
			end else begin
				out_q.tree_from <= '0;
				out_q.tree_to <= '0;
				out_q.tree_cost <= '0;
				out_q.running_total <= total_q;
				out_q.disconnected <= 1'b1;
				out_q.last_edge <= 1'b1;
			end
		end
	end

`ifndef SYNTHESIS
	a_found_cost: assert property (@(posedge clk) disable iff (!arst_n)
		found_q |-> best_q != NO_EDGE)
		else $error("A crossing edge was recorded with the no-edge weight.");
	a_disc_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.disconnected) |-> out_q.last_edge)
		else $error("A disconnected result did not end the run.");
	a_no_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !req.ready)
		else $error("Requests accepted while a result is pending.");
`endif
endmodule

[src/minimum_spanning_tree_engine.sv]
// Top level of the minimum spanning tree engine.
// Loading takes one request per cycle while the controller is idle; each non-final request causes no result.
// After the final request, each round scans the cost memory one entry per cycle within a
// row, each row after a row-start step, then drain, decide and a held output; at most NODES-1 rounds.
// The memory read port and the single compare unit set this rate.
// Reset clears the controller and set labels; the cost matrix is undefined until written.
`timescale 1ns / 1ps
module minimum_spanning_tree_engine #(
	parameter int NODES = 16
) (
	input logic        clk,
	input logic        arst_n,
	mst_chan_if.sink   req,
	mst_chan_if.source res
);
	import mst_pkg::*;

	ctl_cmd_t cmd;
	ctl_sts_t sts;

	mst_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	mst_dpath #(.NODES(NODES)) u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.sts    (sts),
		.req    (req),
		.res    (res)
	);
endmodule
